[src/tzkm_pkg.sv]
// ----------------------------------------------------------------------------
// tzkm_pkg
// Shared types and constants for the touch zone key mask debounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package tzkm_pkg;

  // Operation codes carried by an input beat.
  localparam logic [1:0] OP_TOUCH = 2'd0;
  localparam logic [1:0] OP_FRAME = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  // The remaining code is unused and leaves the state alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_ONE_END   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_TWO_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_THREE_END = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_CENTER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_FLOOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_ENABLE  = 3'd6;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [11:0] RST_ZONE_ONE_END   = 12'd800;
  localparam logic [11:0] RST_ZONE_TWO_END   = 12'd1600;
  localparam logic [11:0] RST_ZONE_THREE_END = 12'd2400;
  localparam logic [11:0] RST_SQUARE_CENTER  = 12'd896;
  localparam logic [15:0] RST_TOUCH_FLOOR    = 16'd500;
  localparam logic [9:0]  RST_DEBOUNCE_TICKS = 10'd30;
  localparam logic [3:0]  RST_SENSOR_ENABLE  = 4'hF;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  channel;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [15:0] touch_size;
  } in_item_t;

  typedef struct packed {
    logic [15:0] debounced_mask;
    logic [15:0] raw_mask;
    logic        changed;
  } out_item_t;

  typedef struct packed {
    logic [11:0] zone_one_end;
    logic [11:0] zone_two_end;
    logic [11:0] zone_three_end;
    logic [11:0] square_center;
    logic [15:0] touch_floor;
    logic [9:0]  debounce_ticks;
    logic [3:0]  sensor_enable;
  } cfg_t;

endpackage

`default_nettype wire

[src/tzkm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// tzkm_cfg_regs
// Configuration register file, written through the cfg beat handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module tzkm_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           wr_en,
  input  wire logic [tzkm_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [tzkm_pkg::CFG_DATA_W-1:0] wr_data,
  output tzkm_pkg::cfg_t                      cfg
);
  import tzkm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the index and replace the addressed field; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        CFG_ZONE_ONE_END:   cfg_nxt.zone_one_end   = wr_data[11:0];
        CFG_ZONE_TWO_END:   cfg_nxt.zone_two_end   = wr_data[11:0];
        CFG_ZONE_THREE_END: cfg_nxt.zone_three_end = wr_data[11:0];
        CFG_SQUARE_CENTER:  cfg_nxt.square_center  = wr_data[11:0];
        CFG_TOUCH_FLOOR:    cfg_nxt.touch_floor    = wr_data[15:0];
        CFG_DEBOUNCE_TICKS: cfg_nxt.debounce_ticks = wr_data[9:0];
        CFG_SENSOR_ENABLE:  cfg_nxt.sensor_enable  = wr_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zone_one_end   <= RST_ZONE_ONE_END;
      cfg_r.zone_two_end   <= RST_ZONE_TWO_END;
      cfg_r.zone_three_end <= RST_ZONE_THREE_END;
      cfg_r.square_center  <= RST_SQUARE_CENTER;
      cfg_r.touch_floor    <= RST_TOUCH_FLOOR;
      cfg_r.debounce_ticks <= RST_DEBOUNCE_TICKS;
      cfg_r.sensor_enable  <= RST_SENSOR_ENABLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[src/tzkm_core.sv]
// ----------------------------------------------------------------------------
// tzkm_core
// Key mapping, frame accumulation and restart-timer debounce state.
// ----------------------------------------------------------------------------
`default_nettype none

module tzkm_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tzkm_pkg::cfg_t      cfg,
  input  wire logic                step,
  input  wire tzkm_pkg::in_item_t  item,
  output tzkm_pkg::out_item_t      result
);
  import tzkm_pkg::*;

  logic [15:0] frame_mask_r, frame_mask_nxt;
  logic [15:0] raw_state_r, raw_state_nxt;
  logic [15:0] stable_state_r, stable_state_nxt;
  logic        pending_r, pending_nxt;
  logic [9:0]  count_r, count_nxt;
  logic        changed;

  logic [1:0]  zone;
  logic [1:0]  quad;
  logic [3:0]  bit_idx;
  logic        hit;

  // Zone along a bar: the first bound the position lies below wins.
  always_comb begin
    if (item.pos_x < cfg.zone_one_end) begin
      zone = 2'd0;
    end else if (item.pos_x < cfg.zone_two_end) begin
      zone = 2'd1;
    end else if (item.pos_x < cfg.zone_three_end) begin
      zone = 2'd2;
    end else begin
      zone = 2'd3;
    end
  end

  // Square quadrant and the resulting button index.
  assign quad    = {item.pos_y >= cfg.square_center, item.pos_x >= cfg.square_center};
  assign bit_idx = (item.channel == 2'd0) ? {quad, 2'b00} : {zone, item.channel};
  assign hit     = cfg.sensor_enable[item.channel] && (item.touch_size >= cfg.touch_floor);

  // Next state for one beat.
  always_comb begin
    frame_mask_nxt   = frame_mask_r;
    raw_state_nxt    = raw_state_r;
    stable_state_nxt = stable_state_r;
    pending_nxt      = pending_r;
    count_nxt        = count_r;
    changed          = 1'b0;
    unique case (item.op)
      OP_TOUCH: begin
        if (hit) begin
          frame_mask_nxt = frame_mask_r | (16'd1 << bit_idx);
        end
      end
      OP_FRAME: begin
        if (frame_mask_r != raw_state_r) begin
          raw_state_nxt = frame_mask_r;
          pending_nxt   = 1'b1;
          count_nxt     = cfg.debounce_ticks;
        end
        frame_mask_nxt = '0;
      end
      OP_TICK: begin
        if (pending_r) begin
          // A count of zero or one expires on this tick.
          if (count_r <= 10'd1) begin
            count_nxt   = '0;
            pending_nxt = 1'b0;
            if (raw_state_r != stable_state_r) begin
              stable_state_nxt = raw_state_r;
              changed          = 1'b1;
            end
          end else begin
            count_nxt = count_r - 10'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_mask_r   <= '0;
      raw_state_r    <= '0;
      stable_state_r <= '0;
      pending_r      <= 1'b0;
      count_r        <= '0;
    end else if (step) begin
      frame_mask_r   <= frame_mask_nxt;
      raw_state_r    <= raw_state_nxt;
      stable_state_r <= stable_state_nxt;
      pending_r      <= pending_nxt;
      count_r        <= count_nxt;
    end
  end

  assign result.debounced_mask = stable_state_nxt;
  assign result.raw_mask       = raw_state_nxt;
  assign result.changed        = changed;

endmodule

`default_nettype wire

[src/touch_zone_key_mask_debounce_top.sv]
// A beat is held in the input register and moves into the result register once
// that is free or being drained. Throughput: one beat per cycle while the result
// is not stalled; the state update is a single pass of compares. A stalled result
// holds the input register, so at most two beats wait inside.
// Reset: synchronous active-low rst_n clears the masks, the debounce countdown
// and both pipeline valids, and loads the configuration defaults.
// ----------------------------------------------------------------------------
// touch_zone_key_mask_debounce_top
// Turns touch reports, frame ends and ticks into a debounced button mask.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_zone_key_mask_debounce_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire tzkm_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output tzkm_pkg::out_item_t                  out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tzkm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tzkm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tzkm_pkg::*;

  cfg_t      cfg;
  in_item_t  in_r;
  logic      in_vld_r;
  out_item_t out_r;
  logic      out_vld_r;
  out_item_t result;
  logic      advance;

  assign cfg_ready = 1'b1;

  tzkm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // The held beat moves on when the result register is free or being drained.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  tzkm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .step   (advance),
    .item   (in_r),
    .result (result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

[src/tzkm_checker.sv]
// ----------------------------------------------------------------------------
// tzkm_checker
// Port-level checks of the debounced mask behavior, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tzkm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire tzkm_pkg::out_item_t out_data
);
  import tzkm_pkg::*;

  logic [15:0] last_deb_r;
  logic        seen_r;
  logic        beat;

  assign beat = out_valid && out_ready;

  // Debounced mask of the last delivered beat, zero from reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_deb_r <= '0;
      seen_r     <= 1'b0;
    end else if (beat) begin
      last_deb_r <= out_data.debounced_mask;
      seen_r     <= 1'b1;
    end
  end

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  // A commit copies the raw mask into the debounced mask.
  a_commit_raw: assert property (@(posedge clk) disable iff (!rst_n)
    beat && out_data.changed |-> out_data.debounced_mask == out_data.raw_mask)
    else $error("commit did not take the raw mask");

  // The debounced mask moves only on a flagged change.
  a_no_silent: assert property (@(posedge clk) disable iff (!rst_n)
    beat && !out_data.changed |-> out_data.debounced_mask == last_deb_r)
    else $error("debounced mask changed without a change flag");

  // A flagged change really differs from what was delivered before.
  a_real_change: assert property (@(posedge clk) disable iff (!rst_n)
    beat && out_data.changed && seen_r |-> out_data.debounced_mask != last_deb_r)
    else $error("change flagged without a new debounced mask");

  // Nothing is offered right after reset.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind touch_zone_key_mask_debounce_top tzkm_checker u_tzkm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

[dv/tzkm_sb_pkg.sv]
// ----------------------------------------------------------------------------
// tzkm_sb_pkg
// Scoreboard for the touch zone key mask debounce block. It keeps its own
// copy of the settings and the mask state, works out the result of every
// accepted input beat and checks the result beats against those in order.
// ----------------------------------------------------------------------------
`default_nettype none

package tzkm_sb_pkg;

  import tzkm_pkg::*;

  // The square sensor sits on channel 0; the bars use channels 1 to 3.
  localparam logic [1:0] SQUARE_CHANNEL = 2'd0;

  class key_mask_scoreboard;

    cfg_t        regs;
    logic [15:0] frame_bits;
    logic [15:0] raw_bits;
    logic [15:0] stable_bits;
    logic        countdown_on;
    logic [9:0]  countdown;
    out_item_t   expected_masks[$];

    int unsigned errors;
    int unsigned checked;
    int unsigned beats;
    int unsigned ticks;
    int unsigned frame_ends;
    int unsigned commits;
    int unsigned reg_writes;

    function new();
      regs = '{zone_one_end:   RST_ZONE_ONE_END,
               zone_two_end:   RST_ZONE_TWO_END,
               zone_three_end: RST_ZONE_THREE_END,
               square_center:  RST_SQUARE_CENTER,
               touch_floor:    RST_TOUCH_FLOOR,
               debounce_ticks: RST_DEBOUNCE_TICKS,
               sensor_enable:  RST_SENSOR_ENABLE};
      frame_bits   = '0;
      raw_bits     = '0;
      stable_bits  = '0;
      countdown_on = 1'b0;
      countdown    = '0;
    endfunction

    function int outstanding();
      return expected_masks.size();
    endfunction

    // Track a register write; each register keeps only its own width.
    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      case (idx)
        CFG_ZONE_ONE_END:   regs.zone_one_end   = data[11:0];
        CFG_ZONE_TWO_END:   regs.zone_two_end   = data[11:0];
        CFG_ZONE_THREE_END: regs.zone_three_end = data[11:0];
        CFG_SQUARE_CENTER:  regs.square_center  = data[11:0];
        CFG_TOUCH_FLOOR:    regs.touch_floor    = data[15:0];
        CFG_DEBOUNCE_TICKS: regs.debounce_ticks = data[9:0];
        CFG_SENSOR_ENABLE:  regs.sensor_enable  = data[3:0];
        default: ;
      endcase
    endfunction

    // Advance the mask state by one accepted input beat and queue the result.
    function void note_beat(in_item_t beat);
      logic [1:0] zone;
      logic [1:0] quad;
      logic [3:0] key_pos;
      out_item_t  want;
      want.changed = 1'b0;
      beats++;
      case (beat.op)
        OP_TOUCH: begin
          if (regs.sensor_enable[beat.channel] &&
              beat.touch_size >= regs.touch_floor) begin
            if (beat.channel == SQUARE_CHANNEL) begin
              quad    = {beat.pos_y >= regs.square_center,
                         beat.pos_x >= regs.square_center};
              key_pos = {quad, 2'b00};
            end else begin
              // The first bound the position lies below picks the zone.
              if (beat.pos_x < regs.zone_one_end) zone = 2'd0;
              else if (beat.pos_x < regs.zone_two_end) zone = 2'd1;
              else if (beat.pos_x < regs.zone_three_end) zone = 2'd2;
              else zone = 2'd3;
              key_pos = {zone, beat.channel};
            end
            frame_bits[key_pos] = 1'b1;
          end
        end
        OP_FRAME: begin
          frame_ends++;
          // A new raw mask restarts the countdown, even one already running.
          if (frame_bits != raw_bits) begin
            raw_bits     = frame_bits;
            countdown_on = 1'b1;
            countdown    = regs.debounce_ticks;
          end
          frame_bits = '0;
        end
        OP_TICK: begin
          ticks++;
          if (countdown_on) begin
            // A length of zero expires on the first tick, as does one.
            if (countdown <= 10'd1) begin
              countdown    = '0;
              countdown_on = 1'b0;
              if (raw_bits != stable_bits) begin
                stable_bits  = raw_bits;
                want.changed = 1'b1;
                commits++;
              end
            end else begin
              countdown = countdown - 10'd1;
            end
          end
        end
        default: ;
      endcase
      want.debounced_mask = stable_bits;
      want.raw_mask       = raw_bits;
      expected_masks.push_back(want);
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      errors++;
      $display("ERROR: result %0d, %s: got 0x%h, expected 0x%h", checked, what, got, want);
    endtask

    // Compare a result beat with the oldest expectation, field by field.
    task check_beat(out_item_t got);
      out_item_t want;
      if (expected_masks.size() == 0) begin
        report_mismatch("result with nothing expected", got.raw_mask, '0);
        return;
      end
      want = expected_masks.pop_front();
      if (got.debounced_mask !== want.debounced_mask)
        report_mismatch("debounced_mask", got.debounced_mask, want.debounced_mask);
      if (got.raw_mask !== want.raw_mask)
        report_mismatch("raw_mask", got.raw_mask, want.raw_mask);
      if (got.changed !== want.changed)
        report_mismatch("changed", 16'(got.changed), 16'(want.changed));
      checked++;
    endtask

  endclass

endpackage

`default_nettype wire

[dv/touch_zone_key_mask_debounce_top_tb.sv]
// ----------------------------------------------------------------------------
// touch_zone_key_mask_debounce_top_tb
// Drives touch reports, frame ends and ticks into the key mask block under
// several register settings and idling patterns, and checks every result
// beat against the scoreboard's own prediction of the debounced mask.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_zone_key_mask_debounce_top_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tzkm_pkg::*;
  import tzkm_sb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    hold_left;
  int unsigned           cycle_count;
  int unsigned           settings_run;
  key_mask_scoreboard    sb;

  touch_zone_key_mask_debounce_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Both handshakes are seen in one process, so a result is always checked
  // before the beat accepted at the same edge is queued.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_beat(out_data);
      if (in_valid && in_ready) sb.note_beat(in_data);
    end
  end

  function automatic in_item_t beat_of(logic [1:0] op, logic [1:0] ch, logic [11:0] x,
                                       logic [11:0] y, logic [15:0] size);
    in_item_t b;
    b.op         = op;
    b.channel    = ch;
    b.pos_x      = x;
    b.pos_y      = y;
    b.touch_size = size;
    return b;
  endfunction

  function automatic logic [11:0] near_edge(logic [11:0] v);
    return v + 12'($urandom_range(2)) - 12'd1;
  endfunction

  // A touch aimed at zone bounds, the square center and the size threshold.
  function automatic in_item_t rand_touch();
    in_item_t    t;
    logic [11:0] bound;
    t.op      = OP_TOUCH;
    t.channel = 2'($urandom_range(3));
    case ($urandom_range(3))
      0: bound = sb.regs.zone_one_end;
      1: bound = sb.regs.zone_two_end;
      2: bound = sb.regs.zone_three_end;
      default: bound = sb.regs.square_center;
    endcase
    t.pos_x = $urandom_range(1) ? 12'($urandom) : near_edge(bound);
    t.pos_y = $urandom_range(1) ? 12'($urandom) : near_edge(sb.regs.square_center);
    case ($urandom_range(9))
      0, 1:    t.touch_size = 16'($urandom);
      2, 3, 4: t.touch_size = sb.regs.touch_floor;
      5, 6:    t.touch_size = sb.regs.touch_floor - 16'd1;
      7:       t.touch_size = 16'hFFFF;
      8:       t.touch_size = 16'd0;
      default: t.touch_size = sb.regs.touch_floor + 16'd1;
    endcase
    return t;
  endfunction

  function automatic cfg_t rand_settings();
    cfg_t s;
    s.zone_one_end   = 12'($urandom_range(0, 1500));
    s.zone_two_end   = 12'($urandom_range(1000, 3000));
    s.zone_three_end = 12'($urandom_range(2000, 4095));
    s.square_center  = 12'($urandom);
    s.touch_floor    = 16'($urandom_range(0, 2000));
    s.debounce_ticks = 10'($urandom_range(1, 6));
    s.sensor_enable  = 4'($urandom);
    return s;
  endfunction

  // Offer one input beat, with random idle cycles ahead of it.
  // Valid stays high after acceptance until the next call or drain().
  task automatic send_beat(input in_item_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop sending and wait until every expected result beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.outstanding() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
    @(negedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    write_reg(CFG_ZONE_ONE_END,   {4'd0, s.zone_one_end});
    write_reg(CFG_ZONE_TWO_END,   {4'd0, s.zone_two_end});
    write_reg(CFG_ZONE_THREE_END, {4'd0, s.zone_three_end});
    write_reg(CFG_SQUARE_CENTER,  {4'd0, s.square_center});
    write_reg(CFG_TOUCH_FLOOR,    s.touch_floor);
    write_reg(CFG_DEBOUNCE_TICKS, {6'd0, s.debounce_ticks});
    write_reg(CFG_SENSOR_ENABLE,  {12'd0, s.sensor_enable});
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  // Idling patterns: none, sender idle, receiver stalling, both.
  task automatic set_idling(input int mode);
    case (mode)
      1:       begin send_idle_pct <= 73; recv_stall_pct <= 0;  end
      2:       begin send_idle_pct <= 0;  recv_stall_pct <= 73; end
      3:       begin send_idle_pct <= 26; recv_stall_pct <= 26; end
      default: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
    endcase
  endtask

  // Frames built from a held set of touches that changes now and then, so
  // the raw mask settles long enough for countdowns to expire. A few frames
  // carry a stray beat or lose their frame end.
  task automatic stream_frames(input int n_items, input logic do_hold, input logic do_pause);
    in_item_t held[$];
    in_item_t stray;
    int       sent;
    int       n_ticks;
    logic     hold_done;
    logic     pause_done;
    sent       = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (sent < n_items) begin
      if (held.size() == 0 || $urandom_range(99) < 30) begin
        held.delete();
        repeat ($urandom_range(4)) held.push_back(rand_touch());
      end
      foreach (held[i]) begin
        send_beat(held[i]);
        sent++;
      end
      if ($urandom_range(99) < 20) begin
        stray = beat_of(2'($urandom_range(3)), 2'($urandom_range(3)), 12'($urandom),
                        12'($urandom), 16'($urandom));
        send_beat(stray);
        if (stray.op != OP_UNUSED) sent++;
      end
      if ($urandom_range(99) < 90) begin
        send_beat(beat_of(OP_FRAME, 2'($urandom), 12'($urandom), 12'($urandom),
                          16'($urandom)));
        sent++;
      end
      if (sb.regs.debounce_ticks <= 10'd40 && $urandom_range(99) < 15)
        n_ticks = int'(sb.regs.debounce_ticks) + 1;
      else
        n_ticks = $urandom_range(3);
      repeat (n_ticks) begin
        send_beat(beat_of(OP_TICK, 2'($urandom), 12'($urandom), 12'($urandom),
                          16'($urandom)));
        sent++;
      end
      // Long receiver hold-off while the sender keeps offering beats.
      if (do_hold && !hold_done && sent >= 20) begin
        hold_left <= 120;
        hold_done = 1'b1;
      end
      // Sender pauses until the pipeline is empty, then carries on.
      if (do_pause && !pause_done && sent >= n_items / 2) begin
        drain();
        pause_done = 1'b1;
      end
    end
  endtask

  task automatic run_phase(input int mode, input cfg_t s, input int n_items,
                           input logic do_hold, input logic do_pause);
    apply_settings(s);
    set_idling(mode);
    stream_frames(n_items, do_hold, do_pause);
    drain();
  endtask

  initial begin
    cfg_t s;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    cycle_count    = 0;
    settings_run   = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed beats under reset settings with a short countdown.
    write_reg(CFG_DEBOUNCE_TICKS, 16'd2);
    cfg_valid <= 1'b0;
    set_idling(0);
    send_beat(beat_of(OP_UNUSED, 2'd3, 12'hFFF, 12'hFFF, 16'hFFFF));
    send_beat(beat_of(OP_TICK, 2'd0, 12'd0, 12'd0, 16'd0));        // tick, nothing pending
    send_beat(beat_of(OP_TOUCH, 2'd0, 12'd0, 12'd0, 16'hFFFF));
    send_beat(beat_of(OP_TOUCH, 2'd0, 12'hFFF, 12'hFFF, 16'd500));
    send_beat(beat_of(OP_TOUCH, 2'd0, 12'd895, 12'd896, 16'd500));
    send_beat(beat_of(OP_TOUCH, 2'd1, 12'd799, 12'd0, 16'd499));   // just too small
    send_beat(beat_of(OP_TOUCH, 2'd1, 12'd800, 12'd0, 16'd500));
    send_beat(beat_of(OP_TOUCH, 2'd2, 12'd2400, 12'hFFF, 16'd600));
    send_beat(beat_of(OP_TOUCH, 2'd3, 12'd0, 12'd0, 16'd500));
    send_beat(beat_of(OP_FRAME, 2'd0, 12'd0, 12'd0, 16'd0));
    send_beat(beat_of(OP_TICK, 2'd0, 12'd0, 12'd0, 16'd0));
    // New raw mask while a countdown runs reloads it.
    send_beat(beat_of(OP_TOUCH, 2'd2, 12'd1599, 12'd0, 16'd500));
    send_beat(beat_of(OP_FRAME, 2'd0, 12'd0, 12'd0, 16'd0));
    send_beat(beat_of(OP_TICK, 2'd0, 12'd0, 12'd0, 16'd0));
    send_beat(beat_of(OP_TICK, 2'd0, 12'd0, 12'd0, 16'd0));
    // Same mask again: the frame end leaves the countdown alone.
    send_beat(beat_of(OP_TOUCH, 2'd2, 12'd1599, 12'd0, 16'd500));
    send_beat(beat_of(OP_FRAME, 2'd0, 12'd0, 12'd0, 16'd0));
    send_beat(beat_of(OP_TICK, 2'd0, 12'd0, 12'd0, 16'd0));
    // Release then press again before expiry: no difference on expiry.
    send_beat(beat_of(OP_FRAME, 2'd0, 12'd0, 12'd0, 16'd0));
    send_beat(beat_of(OP_TOUCH, 2'd2, 12'd1000, 12'd0, 16'd500));
    send_beat(beat_of(OP_FRAME, 2'd0, 12'd0, 12'd0, 16'd0));
    send_beat(beat_of(OP_TICK, 2'd0, 12'd0, 12'd0, 16'd0));
    send_beat(beat_of(OP_TICK, 2'd0, 12'd0, 12'd0, 16'd0));
    drain();

    // Reset bounds with a short countdown, plus a long receiver hold-off.
    s = '{zone_one_end: 12'd800, zone_two_end: 12'd1600, zone_three_end: 12'd2400,
          square_center: 12'd896, touch_floor: 16'd500, debounce_ticks: 10'd3,
          sensor_enable: 4'hF};
    run_phase(0, s, 170, 1'b1, 1'b0);
    // All bounds at zero: every bar touch lands in the top zone.
    s = '{zone_one_end: 12'd0, zone_two_end: 12'd0, zone_three_end: 12'd0,
          square_center: 12'd0, touch_floor: 16'd0, debounce_ticks: 10'd1,
          sensor_enable: 4'hF};
    run_phase(1, s, 170, 1'b0, 1'b0);
    // All bounds at the top: only the largest touch size counts.
    s = '{zone_one_end: 12'hFFF, zone_two_end: 12'hFFF, zone_three_end: 12'hFFF,
          square_center: 12'hFFF, touch_floor: 16'hFFFF, debounce_ticks: 10'd2,
          sensor_enable: 4'hF};
    run_phase(2, s, 170, 1'b0, 1'b0);
    // Bounds out of order, zero countdown length, one sensor switched off.
    s = '{zone_one_end: 12'd3000, zone_two_end: 12'd1000, zone_three_end: 12'd2000,
          square_center: 12'd2048, touch_floor: 16'd1000, debounce_ticks: 10'd0,
          sensor_enable: 4'b1101};
    run_phase(3, s, 170, 1'b0, 1'b1);
    // Longest countdown: no countdown started here expires.
    s = '{zone_one_end: 12'd1024, zone_two_end: 12'd2048, zone_three_end: 12'd3072,
          square_center: 12'd2048, touch_floor: 16'd300, debounce_ticks: 10'd1023,
          sensor_enable: 4'b1010};
    run_phase(0, s, 100, 1'b0, 1'b0);
    run_phase(1, rand_settings(), 170, 1'b0, 1'b0);
    run_phase(2, rand_settings(), 170, 1'b0, 1'b0);
    // Back to reset values, including the default countdown length.
    s = '{zone_one_end: RST_ZONE_ONE_END, zone_two_end: RST_ZONE_TWO_END,
          zone_three_end: RST_ZONE_THREE_END, square_center: RST_SQUARE_CENTER,
          touch_floor: RST_TOUCH_FLOOR, debounce_ticks: RST_DEBOUNCE_TICKS,
          sensor_enable: RST_SENSOR_ENABLE};
    run_phase(3, s, 200, 1'b0, 1'b0);

    repeat (10) @(negedge clk);
    if (sb.outstanding() != 0)
      sb.report_mismatch("results never returned", 16'(sb.outstanding()), '0);
    $display("Covered %0d input beats (%0d frame ends, %0d ticks) over %0d settings",
             sb.beats, sb.frame_ends, sb.ticks, settings_run);
    $display("Checked %0d results with %0d debounced mask commits, %0d register writes",
             sb.checked, sb.commits, sb.reg_writes);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
